// ===== rtl/lmf_pkg.sv =====
package lmf_pkg;

  localparam int SIDE          = 64;
  localparam int RW            = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int SLOTS         = 14;
  localparam int LIQUID_OFFSET = 7;
  localparam int IN_SPAN       = 64;

  typedef logic [RW-1:0]   idx_t;
  typedef logic [SIDE-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_TRIAL   = 2'd0,
    CMD_SWEEP   = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  localparam logic [1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [1:0] REG_WARMUP    = 2'd2;

  typedef struct packed {
    logic       fire;
    cmd_e       cmd;
    logic       flip;
    logic       was_liquid;
    logic [2:0] unlike;
  } stats_op_t;

  typedef struct packed {
    logic [12:0] liquid;
    logic [13:0] contact;
    logic [31:0] samples;
    logic [43:0] sum;
    logic [55:0] square_sum;
  } stats_t;

  // Input indices are six bits wide; this table folds them onto the lattice.
  function automatic logic [IN_SPAN*RW-1:0] build_mod_tab();
    logic [IN_SPAN*RW-1:0] tab;
    tab = '0;
    for (int i = 0; i < IN_SPAN; i++) begin
      tab[i*RW +: RW] = RW'(i % SIDE);
    end
    return tab;
  endfunction

  localparam logic [IN_SPAN*RW-1:0] MOD_TAB = build_mod_tab();

  function automatic idx_t fold_index(logic [5:0] v);
    return MOD_TAB[v*RW +: RW];
  endfunction

  function automatic idx_t wrap_inc(idx_t v);
    return (v == idx_t'(SIDE - 1)) ? '0 : idx_t'(v + 1'b1);
  endfunction

  function automatic idx_t wrap_dec(idx_t v);
    return (v == '0) ? idx_t'(SIDE - 1) : idx_t'(v - 1'b1);
  endfunction

endpackage

// ===== rtl/lattice_metropolis_flip.sv =====
// Metropolis spin-flip engine on a periodic triangular lattice held as rows of bits
// in a two-read-port memory. Every command (site trial, sweep end, threshold load,
// restart) passes a read state and an execute state: the rows above and at the site
// are read together, the row below is read on the second read of the same port, and
// the update is written back while the next beat is accepted, so a beat enters no
// sooner than the last is written back; a stalled output holds the execute state.
// The output register lets a new beat enter while a result waits. Restart clears
// the per-row valid bits at once, so there is no clearing pass. Configuration writes
// are taken at any time but should only be issued while the block is idle.
module lattice_metropolis_flip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [31:0] random_i,
  input  logic [3:0]  table_index_i,
  input  logic [32:0] threshold_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        flipped_o,
  output logic        skipped_o,
  output logic        site_state_o,
  output logic [2:0]  unlike_neighbours_o,
  output logic [12:0] liquid_count_o,
  output logic [13:0] contact_count_o,
  output logic [31:0] sample_count_o,
  output logic [43:0] liquid_sum_o,
  output logic [55:0] liquid_square_sum_o
);

  localparam int CW = (lmf_pkg::RW > 6) ? lmf_pkg::RW : 6;

  logic [5:0]  band_low_q, band_high_q;
  logic [15:0] warmup_q;

  lmf_pkg::state_e state_q, state_d;

  lmf_pkg::cmd_e  cmd_q;
  lmf_pkg::idx_t  row_q, col_q;
  logic [31:0]    rnd_q;
  logic [3:0]     tidx_q;
  logic [32:0]    thr_q;
  logic [32:0]    thr_tab_q [lmf_pkg::SLOTS];
  lmf_pkg::row_t  row_mid_q;

  logic accept, exec, out_free;
  lmf_pkg::idx_t in_row, raddr_a, raddr_b, col_up, col_dn;
  lmf_pkg::row_t row_up, row_dn, wdata;
  logic re_a, we, clear;
  logic me, skip, pass, do_flip, is_trial;
  logic [5:0] nb;
  logic [2:0] unlike;
  logic [3:0] slot;

  lmf_pkg::stats_op_t stats_op;
  lmf_pkg::stats_t    stats_next;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = !((state_q == lmf_pkg::ST_IDLE) ||
                        (state_q == lmf_pkg::ST_EXEC && out_free));
  assign accept     = in_valid_i && !in_stall_o;
  assign exec       = (state_q == lmf_pkg::ST_EXEC) && out_free;

  // Port A reads the site row at acceptance and the row below in the cycle after;
  // port B reads the row above at acceptance.
  assign in_row  = lmf_pkg::fold_index(row_i);
  assign re_a    = accept || (state_q == lmf_pkg::ST_READ);
  assign raddr_a = (state_q == lmf_pkg::ST_READ) ? lmf_pkg::wrap_dec(row_q) : in_row;
  assign raddr_b = lmf_pkg::wrap_inc(in_row);

  lmf_lattice_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .we_i      (we),
    .waddr_i   (row_q),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (row_dn),
    .re_b_i    (accept),
    .raddr_b_i (raddr_b),
    .rdata_b_o (row_up)
  );

  always_comb begin
    col_up   = lmf_pkg::wrap_inc(col_q);
    col_dn   = lmf_pkg::wrap_dec(col_q);
    me       = row_mid_q[col_q];
    nb       = {row_up[col_q], row_dn[col_q], row_mid_q[col_dn], row_mid_q[col_up],
                row_up[col_up], row_dn[col_dn]};
    unlike   = 3'($countones(nb ^ {6{me}}));
    skip     = (CW'(row_q) >= CW'(band_low_q) && CW'(row_q) <= CW'(band_high_q)) ||
               (CW'(col_q) >= CW'(band_low_q) && CW'(col_q) <= CW'(band_high_q));
    slot     = {1'b0, unlike} + (me ? 4'(lmf_pkg::LIQUID_OFFSET) : 4'd0);
    pass     = {1'b0, rnd_q} < thr_tab_q[slot];
    is_trial = (cmd_q == lmf_pkg::CMD_TRIAL);
    do_flip  = is_trial && !skip && pass;
    we       = exec && do_flip;
    clear    = exec && (cmd_q == lmf_pkg::CMD_RESTART);
    wdata    = row_mid_q ^ (lmf_pkg::row_t'(1) << col_q);
  end

  always_comb begin
    stats_op.fire       = exec;
    stats_op.cmd        = cmd_q;
    stats_op.flip       = do_flip;
    stats_op.was_liquid = me;
    stats_op.unlike     = unlike;
  end

  lmf_stats u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (stats_op),
    .warmup_i (warmup_q),
    .next_o   (stats_next)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lmf_pkg::ST_READ;
        end
      end
      lmf_pkg::ST_READ: begin
        state_d = lmf_pkg::ST_EXEC;
      end
      lmf_pkg::ST_EXEC: begin
        if (exec) begin
          state_d = accept ? lmf_pkg::ST_READ : lmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmf_pkg::ST_IDLE;
      out_valid_o <= 1'b0;
      band_low_q  <= 6'd24;
      band_high_q <= 6'd40;
      warmup_q    <= 16'd1000;
      for (int i = 0; i < lmf_pkg::SLOTS; i++) begin
        thr_tab_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          lmf_pkg::REG_BAND_LOW:  band_low_q  <= cfg_data_i[5:0];
          lmf_pkg::REG_BAND_HIGH: band_high_q <= cfg_data_i[5:0];
          lmf_pkg::REG_WARMUP:    warmup_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (exec && cmd_q == lmf_pkg::CMD_LOAD && tidx_q < 4'(lmf_pkg::SLOTS)) begin
        thr_tab_q[tidx_q] <= thr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= lmf_pkg::cmd_e'(command_i);
      row_q  <= in_row;
      col_q  <= lmf_pkg::fold_index(col_i);
      rnd_q  <= random_i;
      tidx_q <= table_index_i;
      thr_q  <= threshold_value_i;
    end
    if (state_q == lmf_pkg::ST_READ) begin
      row_mid_q <= row_dn;
    end
    if (exec) begin
      flipped_o           <= do_flip;
      skipped_o           <= is_trial && skip;
      site_state_o        <= is_trial && (me ^ do_flip);
      unlike_neighbours_o <= (is_trial && !skip) ? unlike : 3'd0;
      liquid_count_o      <= stats_next.liquid;
      contact_count_o     <= stats_next.contact;
      sample_count_o      <= stats_next.samples;
      liquid_sum_o        <= stats_next.sum;
      liquid_square_sum_o <= stats_next.square_sum;
    end
  end

endmodule

// ===== rtl/lmf_lattice_ram.sv =====
module lmf_lattice_ram (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             we_i,
  input  lmf_pkg::idx_t    waddr_i,
  input  lmf_pkg::row_t    wdata_i,
  input  logic             re_a_i,
  input  lmf_pkg::idx_t    raddr_a_i,
  output lmf_pkg::row_t    rdata_a_o,
  input  logic             re_b_i,
  input  lmf_pkg::idx_t    raddr_b_i,
  output lmf_pkg::row_t    rdata_b_o
);

  lmf_pkg::row_t              mem [lmf_pkg::SIDE];
  lmf_pkg::row_t              rd_a_q, rd_b_q;
  logic [lmf_pkg::SIDE-1:0]   valid_q;
  logic                       rv_a_q, rv_b_q;

  // A read at the edge of a write to the same row returns the new row.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rd_a_q <= (we_i && waddr_i == raddr_a_i) ? wdata_i : mem[raddr_a_i];
    end
    if (re_b_i) begin
      rd_b_q <= (we_i && waddr_i == raddr_b_i) ? wdata_i : mem[raddr_b_i];
    end
  end

  // Rows never written since reset or restart read as all gel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_a_q  <= 1'b0;
      rv_b_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_a_i) begin
        rv_a_q <= !clear_i && ((we_i && waddr_i == raddr_a_i) || valid_q[raddr_a_i]);
      end
      if (re_b_i) begin
        rv_b_q <= !clear_i && ((we_i && waddr_i == raddr_b_i) || valid_q[raddr_b_i]);
      end
    end
  end

  assign rdata_a_o = rv_a_q ? rd_a_q : '0;
  assign rdata_b_o = rv_b_q ? rd_b_q : '0;

endmodule

// ===== rtl/lmf_stats.sv =====
module lmf_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lmf_pkg::stats_op_t  op_i,
  input  logic [15:0]         warmup_i,
  output lmf_pkg::stats_t     next_o
);

  lmf_pkg::stats_t stats_q, stats_d;
  logic [31:0]     sweep_q, sweep_d;
  logic [25:0]     square;

  assign square = 26'(stats_q.liquid) * 26'(stats_q.liquid);

  always_comb begin
    stats_d = stats_q;
    sweep_d = sweep_q;
    if (op_i.fire) begin
      case (op_i.cmd)
        lmf_pkg::CMD_TRIAL: begin
          if (op_i.flip) begin
            stats_d.liquid  = op_i.was_liquid ? stats_q.liquid - 13'd1
                                              : stats_q.liquid + 13'd1;
            // Each flip turns unlike contacts into like ones and back: 6 - 2u.
            stats_d.contact = stats_q.contact + 14'd6 - {10'd0, op_i.unlike, 1'b0};
          end
        end
        lmf_pkg::CMD_SWEEP: begin
          sweep_d = sweep_q + 32'd1;
          if (sweep_d >= {16'd0, warmup_i}) begin
            stats_d.samples    = stats_q.samples + 32'd1;
            stats_d.sum        = stats_q.sum + {31'd0, stats_q.liquid};
            stats_d.square_sum = stats_q.square_sum + {30'd0, square};
          end
        end
        lmf_pkg::CMD_RESTART: begin
          stats_d = '0;
          sweep_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= '0;
      sweep_q <= '0;
    end else begin
      stats_q <= stats_d;
      sweep_q <= sweep_d;
    end
  end

  assign next_o = stats_d;

endmodule

// ===== rtl/lmf_checker.sv =====
module lmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        flipped_o,
  input logic        skipped_o,
  input logic [2:0]  unlike_neighbours_o,
  input logic [12:0] liquid_count_o,
  input logic [13:0] contact_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(liquid_count_o) &&
                                   $stable(contact_count_o) && $stable(flipped_o))
    else $error("stalled result beat changed");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skipped_o |-> !flipped_o && unlike_neighbours_o == 3'd0)
    else $error("skipped site reported a flip or neighbour count");

  a_unlike_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unlike_neighbours_o <= 3'd6)
    else $error("unlike neighbour count above six");

  // Every flip moves the contact total by an even amount.
  a_contact_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !contact_count_o[0])
    else $error("contact count is odd");

endmodule

bind lattice_metropolis_flip lmf_checker u_lmf_checker (.*);

// ===== tb/lattice_metropolis_flip_checker.sv =====
module lattice_metropolis_flip_checker
  import lmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [31:0] random_i,
  input  logic [3:0]  table_index_i,
  input  logic [32:0] threshold_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        flipped_i,
  input  logic        skipped_i,
  input  logic        site_state_i,
  input  logic [2:0]  unlike_neighbours_i,
  input  logic [12:0] liquid_count_i,
  input  logic [13:0] contact_count_i,
  input  logic [31:0] sample_count_i,
  input  logic [43:0] liquid_sum_i,
  input  logic [55:0] liquid_square_sum_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          flips_o,
  output int          skips_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        flipped;
    logic        skipped;
    logic        site_state;
    logic [2:0]  unlike;
    logic [12:0] liquid;
    logic [13:0] contact;
    logic [31:0] samples;
    logic [43:0] sum;
    logic [55:0] square_sum;
  } step_result_t;

  logic        spin [SIDE][SIDE];
  logic [32:0] accept_thr [SLOTS];
  logic [12:0] liquid_q;
  logic [13:0] contact_q;
  logic [31:0] sweep_q;
  logic [31:0] samples_q;
  logic [43:0] sum_q;
  logic [55:0] square_sum_q;
  logic [5:0]  band_lo_q;
  logic [5:0]  band_hi_q;
  logic [15:0] warmup_q;

  step_result_t expected_q [$];

  function automatic void clear_run();
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        spin[r][c] = 1'b0;
      end
    end
    liquid_q     = '0;
    contact_q    = '0;
    sweep_q      = '0;
    samples_q    = '0;
    sum_q        = '0;
    square_sum_q = '0;
  endfunction

  function automatic logic in_band(int v);
    return (v >= int'(band_lo_q)) && (v <= int'(band_hi_q));
  endfunction

  // Applies one beat to the local copy of the lattice and totals.
  function automatic step_result_t apply_beat(cmd_e cmd, logic [5:0] row, logic [5:0] col,
                                              logic [31:0] rnd, logic [3:0] slot_in,
                                              logic [32:0] thr_in);
    step_result_t res;
    int           r, c, up, dn, lf, rt, unlike, slot;
    logic         me;
    res = '0;
    case (cmd)
      CMD_TRIAL: begin
        r  = int'(row) % SIDE;
        c  = int'(col) % SIDE;
        me = spin[r][c];
        res.site_state = me;
        if (in_band(r) || in_band(c)) begin
          res.skipped = 1'b1;
        end else begin
          up = (r + 1) % SIDE;
          dn = (r + SIDE - 1) % SIDE;
          rt = (c + 1) % SIDE;
          lf = (c + SIDE - 1) % SIDE;
          unlike = int'(spin[up][c] != me) + int'(spin[dn][c] != me)
                 + int'(spin[r][lf] != me) + int'(spin[r][rt] != me)
                 + int'(spin[up][rt] != me) + int'(spin[dn][lf] != me);
          slot = unlike + (me ? LIQUID_OFFSET : 0);
          res.unlike = 3'(unlike);
          if ({1'b0, rnd} < accept_thr[slot]) begin
            res.flipped    = 1'b1;
            res.site_state = ~me;
            spin[r][c]     = ~me;
            liquid_q  = me ? liquid_q - 13'd1 : liquid_q + 13'd1;
            contact_q = contact_q + 14'd6 - 14'(2 * unlike);
          end
        end
      end
      CMD_SWEEP: begin
        sweep_q = sweep_q + 32'd1;
        if (sweep_q >= {16'd0, warmup_q}) begin
          samples_q    = samples_q + 32'd1;
          sum_q        = sum_q + 44'(liquid_q);
          square_sum_q = square_sum_q + 56'(liquid_q) * 56'(liquid_q);
        end
      end
      CMD_LOAD: begin
        if (int'(slot_in) < SLOTS) accept_thr[slot_in] = thr_in;
      end
      default: begin
        clear_run();
      end
    endcase
    res.liquid     = liquid_q;
    res.contact    = contact_q;
    res.samples    = samples_q;
    res.sum        = sum_q;
    res.square_sum = square_sum_q;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    step_result_t want;
    if (!rst_ni) begin
      clear_run();
      for (int i = 0; i < SLOTS; i++) accept_thr[i] = '0;
      band_lo_q    = 6'd24;
      band_hi_q    = 6'd40;
      warmup_q     = 16'd1000;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      flips_o      = 0;
      skips_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BAND_LOW:  band_lo_q = cfg_data_i[5:0];
          REG_BAND_HIGH: band_hi_q = cfg_data_i[5:0];
          REG_WARMUP:    warmup_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with no outstanding trial, actual flipped=%0d liquid=%0d",
                   $time, flipped_i, liquid_count_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("flipped", 64'(want.flipped), 64'(flipped_i));
          check_field("skipped", 64'(want.skipped), 64'(skipped_i));
          check_field("site_state", 64'(want.site_state), 64'(site_state_i));
          check_field("unlike_neighbours", 64'(want.unlike), 64'(unlike_neighbours_i));
          check_field("liquid_count", 64'(want.liquid), 64'(liquid_count_i));
          check_field("contact_count", 64'(want.contact), 64'(contact_count_i));
          check_field("sample_count", 64'(want.samples), 64'(sample_count_i));
          check_field("liquid_sum", 64'(want.sum), 64'(liquid_sum_i));
          check_field("liquid_square_sum", 64'(want.square_sum), 64'(liquid_square_sum_i));
          checked_o++;
          if (want.flipped) flips_o++;
          if (want.skipped) skips_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_beat(cmd_e'(command_i), row_i, col_i, random_i,
                                        table_index_i, threshold_value_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/lattice_metropolis_flip_test.sv =====
module lattice_metropolis_flip_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lmf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [5:0]  row_i = '0;
  logic [5:0]  col_i = '0;
  logic [31:0] random_i = '0;
  logic [3:0]  table_index_i = '0;
  logic [32:0] threshold_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        flipped_o;
  logic        skipped_o;
  logic        site_state_o;
  logic [2:0]  unlike_neighbours_o;
  logic [12:0] liquid_count_o;
  logic [13:0] contact_count_o;
  logic [31:0] sample_count_o;
  logic [43:0] liquid_sum_o;
  logic [55:0] liquid_square_sum_o;

  int fail_count, pending, checked, flips, skips;
  int send_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int phases_run = 0;

  lattice_metropolis_flip dut (.*);

  lattice_metropolis_flip_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .command_i           (command_i),
    .row_i               (row_i),
    .col_i               (col_i),
    .random_i            (random_i),
    .table_index_i       (table_index_i),
    .threshold_value_i   (threshold_value_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .flipped_i           (flipped_o),
    .skipped_i           (skipped_o),
    .site_state_i        (site_state_o),
    .unlike_neighbours_i (unlike_neighbours_o),
    .liquid_count_i      (liquid_count_o),
    .contact_count_i     (contact_count_o),
    .sample_count_i      (sample_count_o),
    .liquid_sum_i        (liquid_sum_o),
    .liquid_square_sum_i (liquid_square_sum_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .checked_o           (checked),
    .flips_o             (flips),
    .skips_o             (skips)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #(3_000_000);
    $display("lattice_metropolis_flip_test: FAIL");
    $finish;
  end

  // Holds one beat on the input channel until it is taken. Stall is looked at
  // mid-cycle, where it is settled, and the beat counts as taken at the next edge.
  task automatic send_beat(cmd_e cmd, logic [5:0] row, logic [5:0] col, logic [31:0] rnd,
                           logic [3:0] slot, logic [32:0] thr);
    logic taken;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    row_i             <= row;
    col_i             <= col;
    random_i          <= rnd;
    table_index_i     <= slot;
    threshold_value_i <= thr;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    beats_sent++;
  endtask

  task automatic trial_beat(logic [5:0] row, logic [5:0] col, logic [31:0] rnd);
    send_beat(CMD_TRIAL, row, col, rnd, 4'($urandom), {1'($urandom), 32'($urandom)});
  endtask

  task automatic load_beat(logic [3:0] slot, logic [32:0] thr);
    send_beat(CMD_LOAD, 6'($urandom), 6'($urandom), $urandom, slot, thr);
  endtask

  task automatic plain_beat(cmd_e cmd);
    send_beat(cmd, 6'($urandom), 6'($urandom), $urandom, 4'($urandom),
              {1'($urandom), 32'($urandom)});
  endtask

  function automatic logic [32:0] pick_threshold();
    case ($urandom_range(0, 3))
      0:       return 33'h1_0000_0000;
      1:       return 33'd0;
      2:       return {1'b0, 32'($urandom)};
      default: return {1'b1, 32'($urandom)};
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Upper data bits of the band writes carry noise; only six bits are kept.
  task automatic set_regs(logic [5:0] lo, logic [5:0] hi, logic [15:0] warm);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_BAND_LOW;
    cfg_data_i  <= {10'($urandom), lo};
    @(posedge clk_i);
    cfg_index_i <= REG_BAND_HIGH;
    cfg_data_i  <= {10'($urandom), hi};
    @(posedge clk_i);
    cfg_index_i <= REG_WARMUP;
    cfg_data_i  <= warm;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [5:0] lo, logic [5:0] hi, logic [15:0] warm, int mode,
                           int count);
    logic [5:0] base_r, base_c, r, c;
    int         pick;
    send_pct  = (mode == 1) ? 64 : (mode == 3) ? 21 : 0;
    stall_pct = (mode == 2) ? 64 : (mode == 3) ? 21 : 0;
    set_regs(lo, hi, warm);
    for (int s = 0; s < SLOTS; s++) load_beat(4'(s), pick_threshold());
    // Trials mostly land in a small window so that neighbours interact.
    base_r = 6'($urandom);
    base_c = 6'($urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if ($urandom_range(0, 4) != 0) begin
          r = base_r + 6'($urandom_range(0, 5));
          c = base_c + 6'($urandom_range(0, 5));
        end else begin
          r = 6'($urandom);
          c = 6'($urandom);
        end
        trial_beat(r, c, $urandom);
      end else if (pick < 84) begin
        plain_beat(CMD_SWEEP);
      end else if (pick < 98) begin
        load_beat(4'($urandom), pick_threshold());
      end else begin
        plain_beat(CMD_RESTART);
      end
    end
    drain();
    phases_run++;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: band 24..40, warm-up far away, all thresholds zero.
    trial_beat(6'd0, 6'd0, 32'd0);
    trial_beat(6'd30, 6'd5, 32'hFFFF_FFFF);
    trial_beat(6'd5, 6'd40, 32'd0);
    load_beat(4'd0, 33'h1_0000_0000);
    load_beat(4'd14, 33'h1_0000_0000);
    load_beat(4'd15, 33'd0);
    trial_beat(6'd0, 6'd0, 32'hFFFF_FFFF);
    load_beat(4'd7, 33'h1_FFFF_FFFF);
    // The corner site sees the origin through its up-right wrap.
    trial_beat(6'd63, 6'd63, 32'hFFFF_FFFF);
    load_beat(4'd1, 33'h0_8000_0000);
    trial_beat(6'd63, 6'd63, 32'h7FFF_FFFF);
    trial_beat(6'd63, 6'd63, 32'h8000_0000);
    plain_beat(CMD_SWEEP);
    plain_beat(CMD_RESTART);
    drain();

    // Inverted band skips nothing; warm-up zero samples every sweep.
    set_regs(6'd63, 6'd0, 16'd0);
    trial_beat(6'd30, 6'd30, 32'd0);
    plain_beat(CMD_SWEEP);
    plain_beat(CMD_SWEEP);
    load_beat(4'd13, 33'h1_FFFF_FFFF);
    trial_beat(6'd30, 6'd30, 32'hFFFF_FFFF);
    trial_beat(6'd30, 6'd30, 32'd0);
    drain();

    // Whole lattice inside the band, warm-up at its top.
    set_regs(6'd0, 6'd63, 16'hFFFF);
    trial_beat(6'd0, 6'd63, 32'd0);
    trial_beat(6'd30, 6'd30, 32'hFFFF_FFFF);
    plain_beat(CMD_SWEEP);
    drain();

    run_phase(6'd63, 6'd0, 16'd0, 0, 175);
    run_phase(6'd0, 6'd0, 16'd3, 1, 175);
    run_phase(6'd63, 6'd63, 16'hFFFF, 2, 175);
    run_phase(6'd10, 6'd20, 16'd1, 3, 175);
    run_phase(6'd0, 6'd63, 16'd2, 0, 60);
    run_phase(6'($urandom), 6'($urandom), 16'($urandom_range(0, 8)), $urandom_range(0, 3), 175);

    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d beats over %0d setting phases; %0d results checked.",
             beats_sent, phases_run, checked);
    $display("Trials seen flipping: %0d, trials skipped in the band: %0d.", flips, skips);
    if (fail_count == 0 && pending == 0) begin
      $display("lattice_metropolis_flip_test: PASS");
    end else begin
      $display("lattice_metropolis_flip_test: FAIL");
    end
    $finish;
  end

endmodule
